// ----- src/multivalue_hash_table_quadratic_probe_assert.svh -----
// Assertion macros used by the RTL engine.
`ifndef MULTIVALUE_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`define MULTIVALUE_HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MVHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvht assertion failed");

// Next-cycle implication, disabled during reset.
`define MVHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvht assertion failed");

`endif

// ----- src/mvht_pkg.sv -----
`default_nettype none

package mvht_pkg;

    localparam int KEY_BITS   = 8;
    localparam int CAPACITY   = 256;
    localparam int PROBES     = 8;
    localparam int BUCKET_IDS = 16;
    localparam int ID_W       = 20;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int ATT_W  = (PROBES > 1) ? $clog2(PROBES) : 1;
    localparam int SQ_W   = 2 * ATT_W;
    localparam int CNT_W  = $clog2(BUCKET_IDS + 1);
    localparam int IDX_W  = (BUCKET_IDS > 1) ? $clog2(BUCKET_IDS) : 1;
    localparam int ADDR_W = SLOT_W + IDX_W;

    localparam int HASH_SEED  = 5381;
    localparam int HASH_SHIFT = 5;
    localparam int CHAR_ZERO  = 48;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_FIND   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_APPEND    = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_FOUND     = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   found_id;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_meta;

    // DJB2 over the key bits, msb first, each bit as char '0' or '1'.
    // Only the low SLOT_W bits survive the modulo, so the sum is kept that narrow.
    function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_BITS-1:0] k);
        logic [SLOT_W-1:0] h;
        h = SLOT_W'(HASH_SEED);
        for (int b = KEY_BITS - 1; b >= 0; b--) begin
            h = (h << HASH_SHIFT) + h + SLOT_W'(CHAR_ZERO) + SLOT_W'(k[b]);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- src/mvht_req_if.sv -----
`default_nettype none

interface mvht_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [mvht_pkg::KEY_BITS-1:0] key;
    logic [mvht_pkg::ID_W-1:0]   item_id;

    modport source (output valid, operation, key, item_id, input ready);
    modport sink   (input valid, operation, key, item_id, output ready);
endinterface

`default_nettype wire

// ----- src/mvht_rsp_if.sv -----
`default_nettype none

interface mvht_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [mvht_pkg::ID_W-1:0] found_id;
    logic                      last;

    modport source (output valid, status, found_id, last, input ready);
    modport sink   (input valid, status, found_id, last, output ready);
endinterface

`default_nettype wire

// ----- src/mvht_outbuf.sv -----
`default_nettype none

module mvht_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mvht_pkg::t_result i_res,
    input  wire logic              i_push,
    output logic                   o_space,
    mvht_rsp_if.source             o_rsp
);

    mvht_pkg::t_result r_buf [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              pop;
    logic              push;

    assign o_space = (r_cnt != 2'd2);
    assign push    = i_push && o_space;
    assign pop     = o_rsp.valid && o_rsp.ready;

    assign o_rsp.valid    = (r_cnt != 2'd0);
    assign o_rsp.status   = r_buf[r_rp].status;
    assign o_rsp.found_id = r_buf[r_rp].found_id;
    assign o_rsp.last     = r_buf[r_rp].last;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/mvht_engine.sv -----
`default_nettype none
`include "multivalue_hash_table_quadratic_probe_assert.svh"

module mvht_engine (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mvht_req_if.sink              i_req,
    output mvht_pkg::t_result     o_res,
    output logic                  o_push,
    input  wire logic             i_space
);

    localparam int SLOT_W = mvht_pkg::SLOT_W;
    localparam int ATT_W  = mvht_pkg::ATT_W;
    localparam int SQ_W   = mvht_pkg::SQ_W;
    localparam int CNT_W  = mvht_pkg::CNT_W;
    localparam int IDX_W  = mvht_pkg::IDX_W;
    localparam int ADDR_W = mvht_pkg::ADDR_W;
    localparam int ID_W   = mvht_pkg::ID_W;
    localparam int KEY_W  = mvht_pkg::KEY_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CHECK = 4'b0100,
        S_IDOUT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    mvht_pkg::t_op       r_op;
    logic [KEY_W-1:0]    r_key;
    logic [ID_W-1:0]     r_id;
    logic [SLOT_W-1:0]   r_home;
    logic [ATT_W-1:0]    r_att, n_att;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_idx, n_idx;

    logic [mvht_pkg::CAPACITY-1:0] r_used;
    mvht_pkg::t_meta     r_meta [mvht_pkg::CAPACITY];
    mvht_pkg::t_meta     r_meta_q;
    logic [ID_W-1:0]     r_ids [mvht_pkg::CAPACITY * mvht_pkg::BUCKET_IDS];
    logic [ID_W-1:0]     r_id_q;

    logic [SQ_W-1:0]     sq;
    logic [SLOT_W-1:0]   probe_slot;
    logic [CNT_W-1:0]    cnt_cap;
    logic [CNT_W-1:0]    idx_inc;
    logic                used_set;
    logic                meta_we, meta_re;
    logic [SLOT_W-1:0]   meta_waddr;
    mvht_pkg::t_meta     meta_wdata;
    logic                ids_we, ids_re;
    logic [ADDR_W-1:0]   ids_waddr, ids_raddr;
    logic                acc;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;

    assign sq         = SQ_W'({{ATT_W{1'b0}}, r_att} * {{ATT_W{1'b0}}, r_att});
    assign probe_slot = r_home + SLOT_W'(sq);
    assign cnt_cap    = (r_meta_q.count > CNT_W'(mvht_pkg::BUCKET_IDS)) ?
                        CNT_W'(mvht_pkg::BUCKET_IDS) : r_meta_q.count;
    assign idx_inc    = r_idx + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_att      = r_att;
        n_slot     = r_slot;
        n_n        = r_n;
        n_idx      = r_idx;
        o_push     = 1'b0;
        o_res      = '{status: mvht_pkg::ST_NOT_FOUND, found_id: '0, last: 1'b1};
        used_set   = 1'b0;
        meta_we    = 1'b0;
        meta_re    = 1'b0;
        meta_waddr = probe_slot;
        meta_wdata = '{key: r_key, count: CNT_W'(1)};
        ids_we     = 1'b0;
        ids_re     = 1'b0;
        ids_waddr  = {probe_slot, IDX_W'(0)};
        ids_raddr  = {r_slot, IDX_W'(0)};
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_att   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!r_used[probe_slot]) begin
                    o_res.status = (r_op == mvht_pkg::OP_INSERT) ?
                                   mvht_pkg::ST_NEW : mvht_pkg::ST_NOT_FOUND;
                    if (i_space) begin
                        o_push  = 1'b1;
                        n_state = S_IDLE;
                        if (r_op == mvht_pkg::OP_INSERT) begin
                            used_set = 1'b1;
                            meta_we  = 1'b1;
                            ids_we   = 1'b1;
                        end
                    end
                end else begin
                    meta_re = 1'b1;
                    n_slot  = probe_slot;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_meta_q.key == r_key) begin
                    if (r_op == mvht_pkg::OP_INSERT) begin
                        o_res.status = (cnt_cap == CNT_W'(mvht_pkg::BUCKET_IDS)) ?
                                       mvht_pkg::ST_FULL : mvht_pkg::ST_APPEND;
                        meta_waddr = r_slot;
                        meta_wdata = '{key: r_key, count: cnt_cap + CNT_W'(1)};
                        ids_waddr  = {r_slot, cnt_cap[IDX_W-1:0]};
                        if (i_space) begin
                            o_push  = 1'b1;
                            n_state = S_IDLE;
                            if (cnt_cap != CNT_W'(mvht_pkg::BUCKET_IDS)) begin
                                meta_we = 1'b1;
                                ids_we  = 1'b1;
                            end
                        end
                    end else if (cnt_cap == '0) begin
                        if (i_space) begin
                            o_push  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        ids_re  = 1'b1;
                        n_n     = cnt_cap;
                        n_idx   = '0;
                        n_state = S_IDOUT;
                    end
                end else if (r_att == ATT_W'(mvht_pkg::PROBES - 1)) begin
                    o_res.status = (r_op == mvht_pkg::OP_INSERT) ?
                                   mvht_pkg::ST_NO_SLOT : mvht_pkg::ST_NOT_FOUND;
                    if (i_space) begin
                        o_push  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_att   = r_att + ATT_W'(1);
                    n_state = S_PROBE;
                end
            end
            S_IDOUT: begin
                o_res.status   = mvht_pkg::ST_FOUND;
                o_res.found_id = r_id_q;
                o_res.last     = (idx_inc == r_n);
                ids_raddr      = {r_slot, idx_inc[IDX_W-1:0]};
                if (i_space) begin
                    o_push = 1'b1;
                    if (o_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        ids_re = 1'b1;
                        n_idx  = idx_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (used_set) begin
                r_used[probe_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op   <= mvht_pkg::t_op'(i_req.operation);
            r_key  <= i_req.key;
            r_id   <= i_req.item_id;
            r_home <= mvht_pkg::home_slot(i_req.key);
        end
        r_att  <= n_att;
        r_slot <= n_slot;
        r_n    <= n_n;
        r_idx  <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta[meta_waddr] <= meta_wdata;
        end
        if (meta_re) begin
            r_meta_q <= r_meta[probe_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ids_we) begin
            r_ids[ids_waddr] <= r_id;
        end
        if (ids_re) begin
            r_id_q <= r_ids[ids_raddr];
        end
    end

    `MVHT_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, o_push && o_res.last, r_state == S_IDLE)
    `MVHT_ASSERT_IMP(a_insert_single, i_clk, i_rst_n, o_push && (r_op == mvht_pkg::OP_INSERT), o_res.last)
    `MVHT_ASSERT_IMP(a_id_zero, i_clk, i_rst_n, o_push && (o_res.status != mvht_pkg::ST_FOUND), o_res.found_id == '0)
    `MVHT_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state == S_IDOUT, (r_idx < r_n) && (r_n <= CNT_W'(mvht_pkg::BUCKET_IDS)))

endmodule

`default_nettype wire

// ----- src/multivalue_hash_table_quadratic_probe.sv -----
// Channel   Dir  Payload                          Transfer when
// i_req     in   operation, key, item_id          i_req.valid && i_req.ready
// o_rsp     out  status, found_id, last           o_rsp.valid && o_rsp.ready
//
// One request at a time: once it is taken, each occupied slot visited costs a flag check
// then a key/count read and compare; a free slot ends at the flag check; at most 8 probes.
// A find that hits streams one id per cycle out of the id memory while the output
// buffer has space; stored ids are read back through a registered read port.
// A two-entry output buffer absorbs o_rsp stalls; the engine waits while it is full.
// Reset (synchronous, active low) clears all slot flags at once; no clearing pass.
`default_nettype none

module multivalue_hash_table_quadratic_probe (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mvht_req_if.sink   i_req,
    mvht_rsp_if.source o_rsp
);

    mvht_pkg::t_result res;
    logic              push;
    logic              space;

    mvht_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_res   (res),
        .o_push  (push),
        .i_space (space)
    );

    mvht_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_push  (push),
        .o_space (space),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ----- tb/multivalue_hash_table_quadratic_probe_tb.sv -----
`timescale 1ns / 100ps

module multivalue_hash_table_quadratic_probe_tb;

    localparam int ITEM_TOTAL = 410;
    localparam int DIR_ROWS   = 20;
    localparam int HOT_KEYS   = 12;

    typedef struct {
        mvht_pkg::t_op                 op;
        logic [mvht_pkg::KEY_BITS-1:0] key;
        logic [mvht_pkg::ID_W-1:0]     id;
        bit                            typed;
        mvht_pkg::t_status             st;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    mvht_req_if req_if ();
    mvht_rsp_if rsp_if ();

    multivalue_hash_table_quadratic_probe u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // table image
    bit                        slot_used [mvht_pkg::CAPACITY];
    logic [7:0]                slot_key  [mvht_pkg::CAPACITY];
    int                        slot_cnt  [mvht_pkg::CAPACITY];
    logic [mvht_pkg::ID_W-1:0] slot_ids  [mvht_pkg::CAPACITY][mvht_pkg::BUCKET_IDS];

    mvht_pkg::t_result         expected_rsp [$];
    mvht_pkg::t_result         step_rsp [$];
    mvht_pkg::t_result         got_r;
    mvht_pkg::t_result         exp_r;
    int                        mismatches = 0;
    int                        n_sent = 0;
    bit                        calm = 1'b0;
    logic [7:0]                hot_keys [HOT_KEYS];

    // cluster keys 87..D2 share one home slot; E1 too, never inserted
    t_row dir_rows [DIR_ROWS] = '{
        '{mvht_pkg::OP_FIND,   8'h00, 20'h00000, 1'b1, mvht_pkg::ST_NOT_FOUND},
        '{mvht_pkg::OP_INSERT, 8'h00, 20'h00000, 1'b1, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h00, 20'hFFFFF, 1'b1, mvht_pkg::ST_APPEND},
        '{mvht_pkg::OP_FIND,   8'h00, 20'hFFFFF, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'hFF, 20'hAAAAA, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'hFF, 20'h55555, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_FIND,   8'hFF, 20'h00000, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_FIND,   8'h01, 20'h12345, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h87, 20'h10001, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h4B, 20'h20002, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h33, 20'h30003, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h2D, 20'h40004, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h1E, 20'h50005, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'h78, 20'h60006, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'hB4, 20'h70007, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'hCC, 20'h80008, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_INSERT, 8'hD2, 20'h90009, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_FIND,   8'hE1, 20'h00000, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_FIND,   8'h87, 20'h00000, 1'b0, mvht_pkg::ST_NEW},
        '{mvht_pkg::OP_FIND,   8'hD2, 20'h00000, 1'b0, mvht_pkg::ST_NEW}
    };

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic mvht_pkg::t_result mk_rsp(mvht_pkg::t_status st,
                                                 logic [mvht_pkg::ID_W-1:0] id,
                                                 logic last);
        mvht_pkg::t_result r;
        r.status   = st;
        r.found_id = id;
        r.last     = last;
        return r;
    endfunction

    function automatic void add_step(mvht_pkg::t_result r);
        step_rsp = {step_rsp, r};
    endfunction

    function automatic int home_of(logic [7:0] key);
        longint unsigned h;
        h = 64'd5381;
        for (int b = 7; b >= 0; b--) begin
            h = h * 33 + 48 + key[b];
        end
        return int'(h % mvht_pkg::CAPACITY);
    endfunction

    function automatic void table_step(mvht_pkg::t_op op, logic [7:0] key,
                                       logic [mvht_pkg::ID_W-1:0] id);
        int slot;
        int n;
        step_rsp.delete();
        for (int a = 0; a < mvht_pkg::PROBES; a++) begin
            slot = (home_of(key) + a * a) % mvht_pkg::CAPACITY;
            if (!slot_used[slot]) begin
                if (op == mvht_pkg::OP_INSERT) begin
                    slot_used[slot]   = 1'b1;
                    slot_key[slot]    = key;
                    slot_cnt[slot]    = 1;
                    slot_ids[slot][0] = id;
                    add_step(mk_rsp(mvht_pkg::ST_NEW, '0, 1'b1));
                end else begin
                    add_step(mk_rsp(mvht_pkg::ST_NOT_FOUND, '0, 1'b1));
                end
                return;
            end
            if (slot_key[slot] == key) begin
                n = slot_cnt[slot];
                if (op == mvht_pkg::OP_INSERT) begin
                    if (n >= mvht_pkg::BUCKET_IDS) begin
                        add_step(mk_rsp(mvht_pkg::ST_FULL, '0, 1'b1));
                    end else begin
                        slot_ids[slot][n] = id;
                        slot_cnt[slot]    = n + 1;
                        add_step(mk_rsp(mvht_pkg::ST_APPEND, '0, 1'b1));
                    end
                end else if (n == 0) begin
                    add_step(mk_rsp(mvht_pkg::ST_NOT_FOUND, '0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        add_step(mk_rsp(mvht_pkg::ST_FOUND, slot_ids[slot][i], i == n - 1));
                    end
                end
                return;
            end
        end
        add_step(mk_rsp(op == mvht_pkg::OP_INSERT ? mvht_pkg::ST_NO_SLOT
                                                  : mvht_pkg::ST_NOT_FOUND, '0, 1'b1));
    endfunction

    task automatic send_req(mvht_pkg::t_op op, logic [7:0] key,
                            logic [mvht_pkg::ID_W-1:0] id,
                            bit typed = 1'b0, mvht_pkg::t_status st = mvht_pkg::ST_NEW);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 16) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid     = 1'b1;
        req_if.operation = op;
        req_if.key       = key;
        req_if.item_id   = id;
        do @(posedge i_clk); while (!req_if.ready);
        table_step(op, key, id);
        if (typed) begin
            expected_rsp = {expected_rsp, mk_rsp(st, '0, 1'b1)};
        end else begin
            expected_rsp = {expected_rsp, step_rsp};
        end
        n_sent++;
    endtask

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_r = mk_rsp(mvht_pkg::t_status'(rsp_if.status), rsp_if.found_id,
                           rsp_if.last);
            if (expected_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer status=%0d found_id=%05h last=%0b",
                         $time, got_r.status, got_r.found_id, got_r.last);
            end else begin
                exp_r = expected_rsp.pop_front();
                if (got_r.status !== exp_r.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, got_r.status);
                end
                if (got_r.found_id !== exp_r.found_id) begin
                    mismatches++;
                    $display("%0t: found_id expected %05h actual %05h",
                             $time, exp_r.found_id, got_r.found_id);
                end
                if (got_r.last !== exp_r.last) begin
                    mismatches++;
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_r.last, got_r.last);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("multivalue_hash_table_quadratic_probe_tb: FAIL");
        $finish;
    end

    initial begin
        int         kind;
        int         npool;
        logic [7:0] pool [4];
        logic [7:0] k;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = mvht_pkg::OP_INSERT;
        req_if.key       = '0;
        req_if.item_id   = '0;
        foreach (hot_keys[i]) hot_keys[i] = 8'($urandom);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].op, dir_rows[i].key, dir_rows[i].id,
                     dir_rows[i].typed, dir_rows[i].st);
        end

        while (n_sent < ITEM_TOTAL) begin
            calm = (n_sent >= 180 && n_sent < 260);
            kind = $urandom_range(9);
            if (kind < 6) begin
                npool = $urandom_range(1, 4);
                for (int i = 0; i < npool; i++) begin
                    pool[i] = ($urandom_range(9) < 7) ? hot_keys[$urandom_range(HOT_KEYS - 1)]
                                                      : 8'($urandom);
                end
                repeat ($urandom_range(2, 12)) begin
                    send_req(mvht_pkg::OP_INSERT, pool[$urandom_range(npool - 1)],
                             20'($urandom));
                end
                for (int i = 0; i < npool; i++) begin
                    send_req(mvht_pkg::OP_FIND, pool[i], 20'($urandom));
                end
            end else if (kind == 6) begin
                // drive one bucket past its limit
                k = hot_keys[$urandom_range(HOT_KEYS - 1)];
                repeat (mvht_pkg::BUCKET_IDS + 2) begin
                    send_req(mvht_pkg::OP_INSERT, k, 20'($urandom));
                end
                send_req(mvht_pkg::OP_FIND, k, 20'($urandom));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_req(mvht_pkg::t_op'($urandom_range(1)), 8'($urandom),
                             20'($urandom));
                end
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("multivalue_hash_table_quadratic_probe_tb: PASS");
        end else begin
            $display("multivalue_hash_table_quadratic_probe_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- multivalue_hash_table_quadratic_probe.f -----
+incdir+src
src/mvht_pkg.sv
src/mvht_req_if.sv
src/mvht_rsp_if.sv
src/mvht_outbuf.sv
src/mvht_engine.sv
src/multivalue_hash_table_quadratic_probe.sv
tb/multivalue_hash_table_quadratic_probe_tb.sv
